[sv/usrc_pkg.sv]
// Shared types and constants for the ultrasonic ranger controller.
// No dependencies; used by every file of the block by scoped names.
package usrc_pkg;

	localparam int TICK_W  = 8;
	localparam int CAP_W   = 16;
	localparam int DIST_W  = 11;
	localparam int OVF_W   = 2;
	localparam int CFG_W   = 8;

	localparam logic [TICK_W-1:0] DEFAULT_PERIOD = 8'd25;
	localparam logic [OVF_W-1:0]  OVF_LIMIT      = 2'd2;
	localparam logic [DIST_W-1:0] MAX_DISTANCE   = 11'd1129;

	// distance = span / 58 done as span * ceil(2^21 / 58) >> 21, exact for 16-bit spans
	localparam int ECHO_DIVISOR = 58;
	localparam int DIV_SHIFT    = 21;
	localparam int DIV_RECIP    = ((1 << DIV_SHIFT) + ECHO_DIVISOR - 1) / ECHO_DIVISOR;

	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_CAPTURE  = 2'd1,
		OP_OVERFLOW = 2'd2
	} opcode_t;

	typedef enum logic {
		CFG_ENABLED = 1'b0,
		CFG_PERIOD  = 1'b1
	} cfg_index_t;

endpackage

[sv/ultrasonic_ranger_controller.sv]
// Ultrasonic ranger controller top level: input register, state update, result register.
// Depends on usrc_pkg and usrc_span_div.
//
// Each input word gives one result word. A word is taken into an input register,
// its tick, capture or overflow update and the distance division (one 16x16
// reciprocal multiply) run from that register, and the result lands in an output
// register: one word per cycle sustained while results are read. While a result
// waits unread the input register takes one more word and then holds. Configuration
// writes take effect at once and are meant for when no word is in flight.
module ultrasonic_ranger_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [usrc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic [usrc_pkg::CAP_W-1:0]    capture_value,
	input  logic                          echo_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          trigger_level,
	output logic [usrc_pkg::DIST_W-1:0]   distance_cm,
	output logic                          distance_updated
);

	logic                           enabled_q;
	logic [usrc_pkg::TICK_W-1:0]    period_q;

	logic                           valid_s1;
	usrc_pkg::opcode_t              op_s1;
	logic [usrc_pkg::CAP_W-1:0]     cap_s1;
	logic                           echo_s1;

	logic [usrc_pkg::TICK_W-1:0]    tick_count_q;
	logic                           trigger_q;
	logic [usrc_pkg::CAP_W-1:0]     prev_capture_q;
	logic [usrc_pkg::OVF_W-1:0]     ovf_count_q;
	logic                           echo_high_q;
	logic [usrc_pkg::DIST_W-1:0]    distance_q;

	logic                           out_valid_q;
	logic                           updated_q;

	logic                           advance;
	logic                           fire;
	logic [usrc_pkg::TICK_W-1:0]    cnt_inc;
	logic [usrc_pkg::DIST_W-1:0]    quotient;

	logic [usrc_pkg::TICK_W-1:0]    tick_count_d;
	logic                           trigger_d;
	logic [usrc_pkg::CAP_W-1:0]     prev_capture_d;
	logic [usrc_pkg::OVF_W-1:0]     ovf_count_d;
	logic                           echo_high_d;
	logic [usrc_pkg::DIST_W-1:0]    distance_d;
	logic                           updated_d;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			period_q  <= usrc_pkg::DEFAULT_PERIOD;
		end else if (cfg_we) begin
			case (usrc_pkg::cfg_index_t'(cfg_index))
				usrc_pkg::CFG_ENABLED: enabled_q <= cfg_data[0];
				usrc_pkg::CFG_PERIOD:  period_q  <= cfg_data;
				default:               enabled_q <= enabled_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= usrc_pkg::opcode_t'(opcode);
			cap_s1  <= capture_value;
			echo_s1 <= echo_level;
		end
	end

	usrc_span_div u_span_div (
		.prev_capture (prev_capture_q),
		.capture      (cap_s1),
		.distance     (quotient)
	);

	assign cnt_inc = tick_count_q + usrc_pkg::TICK_W'(1);

	always_comb begin
		tick_count_d   = tick_count_q;
		trigger_d      = trigger_q;
		prev_capture_d = prev_capture_q;
		ovf_count_d    = ovf_count_q;
		echo_high_d    = echo_high_q;
		distance_d     = distance_q;
		updated_d      = 1'b0;
		case (op_s1)
			usrc_pkg::OP_TICK: begin
				if (enabled_q) begin
					tick_count_d = cnt_inc;
					if (cnt_inc == usrc_pkg::TICK_W'(1)) begin
						trigger_d = 1'b0;
					end
					if (cnt_inc >= period_q) begin
						tick_count_d = '0;
						if (!echo_s1) begin
							trigger_d = 1'b1;
						end
					end
				end
			end
			usrc_pkg::OP_CAPTURE: begin
				if (!echo_s1) begin
					if (echo_high_q && ovf_count_q < usrc_pkg::OVF_LIMIT) begin
						distance_d = quotient;
						updated_d  = 1'b1;
					end
					echo_high_d = 1'b0;
				end else begin
					echo_high_d = 1'b1;
				end
				prev_capture_d = cap_s1;
				ovf_count_d    = '0;
			end
			usrc_pkg::OP_OVERFLOW: begin
				if (ovf_count_q < usrc_pkg::OVF_LIMIT) begin
					ovf_count_d = ovf_count_q + usrc_pkg::OVF_W'(1);
				end
			end
			default: begin
				updated_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			trigger_q      <= 1'b0;
			prev_capture_q <= '0;
			ovf_count_q    <= '0;
			echo_high_q    <= 1'b0;
			distance_q     <= '0;
			out_valid_q    <= 1'b0;
			updated_q      <= 1'b0;
		end else if (fire) begin
			tick_count_q   <= tick_count_d;
			trigger_q      <= trigger_d;
			prev_capture_q <= prev_capture_d;
			ovf_count_q    <= ovf_count_d;
			echo_high_q    <= echo_high_d;
			distance_q     <= distance_d;
			out_valid_q    <= 1'b1;
			updated_q      <= updated_d;
		end else if (out_ready) begin
			out_valid_q    <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign trigger_level    = trigger_q;
	assign distance_cm      = distance_q;
	assign distance_updated = updated_q;

endmodule

[sv/usrc_span_div.sv]
// Echo span to distance: (previous - capture) mod 2^16, divided by 58.
// Depends on usrc_pkg for widths and the reciprocal constant.
module usrc_span_div (
	input  logic [usrc_pkg::CAP_W-1:0]  prev_capture,
	input  logic [usrc_pkg::CAP_W-1:0]  capture,
	output logic [usrc_pkg::DIST_W-1:0] distance
);

	localparam logic [usrc_pkg::CAP_W-1:0] Recip = usrc_pkg::CAP_W'(usrc_pkg::DIV_RECIP);

	logic [usrc_pkg::CAP_W-1:0]   span;
	logic [2*usrc_pkg::CAP_W-1:0] product;

	assign span     = prev_capture - capture;
	assign product  = {{usrc_pkg::CAP_W{1'b0}}, span} * {{usrc_pkg::CAP_W{1'b0}}, Recip};
	assign distance = product[usrc_pkg::DIV_SHIFT +: usrc_pkg::DIST_W];

endmodule

[sv/usrc_checker.sv]
// Port-level checks for the ultrasonic ranger controller, bound to the top level.
// Depends on usrc_pkg and ultrasonic_ranger_controller.
module usrc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        trigger_level,
	input  logic [usrc_pkg::DIST_W-1:0] distance_cm,
	input  logic                        distance_updated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(distance_cm) && $stable(trigger_level)
			&& $stable(distance_updated))
		else $error("result word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input held off with no result pending");

	a_distance_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_cm <= usrc_pkg::MAX_DISTANCE)
		else $error("distance out of range");

endmodule

bind ultrasonic_ranger_controller usrc_checker u_usrc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.trigger_level    (trigger_level),
	.distance_cm      (distance_cm),
	.distance_updated (distance_updated)
);
